// ----- rtl/core/minv_pkg.sv -----
// shared types and constants for the 3x3 matrix inverse pipeline
package minv_pkg;

	localparam int MATRIX_DIM = 3;
	localparam int DW         = 32;
	localparam int DETW       = 64;
	localparam int CMAGW      = 64;
	localparam int ACCW       = 98;
	localparam int QBITS      = 33;
	localparam int DIV_LAT    = QBITS + 2;
	localparam int FRONT_LAT  = 8;
	localparam int TOTAL_LAT  = FRONT_LAT + DIV_LAT;

	localparam logic [DETW-1:0] DET_POS_MAX = {1'b0, {(DETW-1){1'b1}}};
	localparam logic [DETW-1:0] DET_NEG_MAX = {1'b1, {(DETW-1){1'b0}}};
	localparam logic [DW-1:0]   INV_POS_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0]   INV_NEG_MAX = {1'b1, {(DW-1){1'b0}}};

	typedef struct packed {
		logic signed [DW-1:0] in_r0c0;
		logic signed [DW-1:0] in_r0c1;
		logic signed [DW-1:0] in_r0c2;
		logic signed [DW-1:0] in_r1c0;
		logic signed [DW-1:0] in_r1c1;
		logic signed [DW-1:0] in_r1c2;
		logic signed [DW-1:0] in_r2c0;
		logic signed [DW-1:0] in_r2c1;
		logic signed [DW-1:0] in_r2c2;
	} mtx_item_t;

	typedef struct packed {
		logic signed [DW-1:0]   inv_r0c0;
		logic signed [DW-1:0]   inv_r0c1;
		logic signed [DW-1:0]   inv_r0c2;
		logic signed [DW-1:0]   inv_r1c0;
		logic signed [DW-1:0]   inv_r1c1;
		logic signed [DW-1:0]   inv_r1c2;
		logic signed [DW-1:0]   inv_r2c0;
		logic signed [DW-1:0]   inv_r2c1;
		logic signed [DW-1:0]   inv_r2c2;
		logic signed [DETW-1:0] det_value;
		logic                   singular;
	} inv_item_t;

endpackage

// ----- rtl/core/minv_if.sv -----
// valid/ready channel interfaces for matrix and inverse transactions
interface minv_mtx_if;
	logic                  valid;
	logic                  ready;
	minv_pkg::mtx_item_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface minv_inv_if;
	logic                  valid;
	logic                  ready;
	minv_pkg::inv_item_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/minv_div.sv -----
// one pipelined restoring divider lane with rounding and 32-bit saturation
module minv_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [minv_pkg::CMAGW-1:0] mag,
	input  logic                       neg,
	input  logic [minv_pkg::CMAGW-1:0] dmag,
	output logic [minv_pkg::DW-1:0]    res
);
	import minv_pkg::*;

	logic [CMAGW-1:0] rem_s  [0:QBITS];
	logic [QBITS-1:0] quo_s  [0:QBITS];
	logic [CMAGW-1:0] d_s    [0:QBITS];
	logic             neg_s  [0:QBITS];
	logic             ovf_s  [0:QBITS];
	logic             zero_s [0:QBITS];
	logic [DW-1:0]    res_s;

	// quotient of 2^QBITS or more saturates, unless the divisor is zero
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= mag;
			quo_s[0]  <= '0;
			d_s[0]    <= dmag;
			neg_s[0]  <= neg;
			ovf_s[0]  <= (mag >> QBITS) >= dmag;
			zero_s[0] <= (dmag == '0);
		end
	end

	for (genvar k = 1; k <= QBITS; k++) begin : g_step
		localparam int B = QBITS - k;
		logic [CMAGW+QBITS-1:0] rem_x;
		logic [CMAGW+QBITS-1:0] dsh;
		logic                   take;
		assign rem_x = {{QBITS{1'b0}}, rem_s[k-1]};
		assign dsh   = {{QBITS{1'b0}}, d_s[k-1]} << B;
		assign take  = rem_x >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? CMAGW'(rem_x - dsh) : rem_s[k-1];
				quo_s[k]  <= {quo_s[k-1][QBITS-2:0], take};
				d_s[k]    <= d_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				zero_s[k] <= zero_s[k-1];
			end
		end
	end

	logic             rnd;
	logic [QBITS:0]   qr;
	logic [DW-1:0]    res_c;

	always_comb begin
		rnd = {rem_s[QBITS], 1'b0} >= {1'b0, d_s[QBITS]};
		qr  = {1'b0, quo_s[QBITS]} + {{QBITS{1'b0}}, rnd};
		if (zero_s[QBITS]) begin
			res_c = '0;
		end else if (!neg_s[QBITS]) begin
			res_c = (ovf_s[QBITS] || qr > (QBITS+1)'(INV_POS_MAX)) ? INV_POS_MAX : qr[DW-1:0];
		end else begin
			res_c = (ovf_s[QBITS] || qr > (QBITS+1)'(INV_NEG_MAX)) ? INV_NEG_MAX
				: DW'(-qr[DW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s <= res_c;
		end
	end

	assign res = res_s;

endmodule

// ----- rtl/core/matrix_inverse_3x3.sv -----
// 3x3 matrix inverse by adjugate: cofactors, determinant, pipelined division
//
// mtx channel takes one matrix per transaction: nine signed Q16.16 entries.
// inv channel gives the nine Q16.16 inverse entries (rounded to nearest,
// saturated), the Q48.16 determinant and a singular flag. When the rounded
// determinant is zero, singular is set and the inverse entries are zero.
// An accepted matrix passes through eight front stages (capture, cofactor
// products, cofactors, split determinant products, recombination, sum,
// magnitudes, rounding and saturation) followed by nine 35-stage restoring
// divider lanes, one quotient bit per step stage. Throughput is one matrix
// per cycle unless stalled. The whole pipeline advances together: it moves
// whenever the output stage is empty or the result is being taken, so a
// stalled receiver holds every stage in place and mtx.ready drops until
// the result is taken. Nothing is lost or repeated across a stall.
// Reset clears all valid bits; the pipeline comes out of reset empty and
// ready.
module matrix_inverse_3x3 (
	input  logic         clk,
	input  logic         arst_n,
	minv_mtx_if.sink     mtx,
	minv_inv_if.source   inv
);
	import minv_pkg::*;

	logic en;
	logic vld_q [1:TOTAL_LAT];

	assign en        = !vld_q[TOTAL_LAT] || inv.ready;
	assign mtx.ready = en;
	assign inv.valid = vld_q[TOTAL_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= TOTAL_LAT; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[1] <= mtx.valid;
			for (int i = 2; i <= TOTAL_LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// stage 1: capture matrix
	logic signed [DW-1:0] m_s1 [MATRIX_DIM][MATRIX_DIM];
	always_ff @(posedge clk) begin
		if (en) begin
			m_s1[0][0] <= mtx.data.in_r0c0;
			m_s1[0][1] <= mtx.data.in_r0c1;
			m_s1[0][2] <= mtx.data.in_r0c2;
			m_s1[1][0] <= mtx.data.in_r1c0;
			m_s1[1][1] <= mtx.data.in_r1c1;
			m_s1[1][2] <= mtx.data.in_r1c2;
			m_s1[2][0] <= mtx.data.in_r2c0;
			m_s1[2][1] <= mtx.data.in_r2c1;
			m_s1[2][2] <= mtx.data.in_r2c2;
		end
	end

	// stage 2: the two products of every 2x2 minor
	logic signed [2*DW-1:0] pa_s2 [MATRIX_DIM][MATRIX_DIM];
	logic signed [2*DW-1:0] pb_s2 [MATRIX_DIM][MATRIX_DIM];
	logic signed [DW-1:0]   r0_s2 [MATRIX_DIM];
	always_ff @(posedge clk) begin
		int ra, rb, ca, cb;
		if (en) begin
			for (int i = 0; i < MATRIX_DIM; i++) begin
				for (int j = 0; j < MATRIX_DIM; j++) begin
					ra = (i == 0) ? 1 : 0;
					rb = (i == 2) ? 1 : 2;
					ca = (j == 0) ? 1 : 0;
					cb = (j == 2) ? 1 : 2;
					pa_s2[i][j] <= m_s1[ra][ca] * m_s1[rb][cb];
					pb_s2[i][j] <= m_s1[ra][cb] * m_s1[rb][ca];
				end
			end
			for (int j = 0; j < MATRIX_DIM; j++) r0_s2[j] <= m_s1[0][j];
		end
	end

	// stage 3: signed cofactors, alternating sign on odd positions
	logic signed [CMAGW-1:0] cof_s3 [MATRIX_DIM][MATRIX_DIM];
	logic signed [DW-1:0]    r0_s3  [MATRIX_DIM];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < MATRIX_DIM; i++) begin
				for (int j = 0; j < MATRIX_DIM; j++) begin
					cof_s3[i][j] <= (((i + j) % 2) == 1) ? (pb_s2[i][j] - pa_s2[i][j])
						: (pa_s2[i][j] - pb_s2[i][j]);
				end
			end
			for (int j = 0; j < MATRIX_DIM; j++) r0_s3[j] <= r0_s2[j];
		end
	end

	// stage 4: row-0 expansion, 64x32 products split in two halves
	logic signed [2*DW-1:0]  ph_s4  [MATRIX_DIM];
	logic signed [2*DW:0]    pl_s4  [MATRIX_DIM];
	logic signed [CMAGW-1:0] cof_s4 [MATRIX_DIM][MATRIX_DIM];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < MATRIX_DIM; j++) begin
				ph_s4[j] <= r0_s3[j] * $signed(cof_s3[0][j][CMAGW-1:DW]);
				pl_s4[j] <= r0_s3[j] * $signed({1'b0, cof_s3[0][j][DW-1:0]});
			end
			cof_s4 <= cof_s3;
		end
	end

	// stage 5: recombine halves into full terms
	logic signed [3*DW:0]    term_s5 [MATRIX_DIM];
	logic signed [CMAGW-1:0] cof_s5  [MATRIX_DIM][MATRIX_DIM];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < MATRIX_DIM; j++) begin
				term_s5[j] <= $signed({ph_s4[j][2*DW-1], ph_s4[j], {DW{1'b0}}})
					+ $signed({{DW{pl_s4[j][2*DW]}}, pl_s4[j]});
			end
			cof_s5 <= cof_s4;
		end
	end

	// stage 6: exact determinant
	logic signed [ACCW-1:0]  acc_s6;
	logic signed [CMAGW-1:0] cof_s6 [MATRIX_DIM][MATRIX_DIM];
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s6 <= ACCW'(term_s5[0]) + ACCW'(term_s5[1]) + ACCW'(term_s5[2]);
			cof_s6 <= cof_s5;
		end
	end

	// stage 7: determinant magnitude, cofactor magnitudes and signs
	logic [ACCW-1:0]  amag_s7;
	logic             dneg_s7;
	logic [CMAGW-1:0] cmag_s7 [MATRIX_DIM][MATRIX_DIM];
	logic             cneg_s7 [MATRIX_DIM][MATRIX_DIM];
	always_ff @(posedge clk) begin
		if (en) begin
			dneg_s7 <= acc_s6[ACCW-1];
			amag_s7 <= acc_s6[ACCW-1] ? ACCW'(-acc_s6) : ACCW'(acc_s6);
			for (int i = 0; i < MATRIX_DIM; i++) begin
				for (int j = 0; j < MATRIX_DIM; j++) begin
					cneg_s7[i][j] <= cof_s6[i][j][CMAGW-1];
					cmag_s7[i][j] <= cof_s6[i][j][CMAGW-1] ? CMAGW'(-cof_s6[i][j])
						: CMAGW'(cof_s6[i][j]);
				end
			end
		end
	end

	// stage 8: round determinant to Q48.16 and saturate
	logic [ACCW-1:0]  rsum;
	logic             dovf;
	logic [DETW-1:0]  draw;
	logic [DETW-1:0]  dsat;
	always_comb begin
		rsum = amag_s7 + (ACCW'(1) << (DW - 1));
		dovf = rsum[ACCW-1:DETW+DW] != '0;
		draw = rsum[DETW+DW-1:DW];
		if (!dneg_s7) dsat = (dovf || draw > DET_POS_MAX) ? DET_POS_MAX : draw;
		else          dsat = (dovf || draw > DET_NEG_MAX) ? DET_NEG_MAX : draw;
	end

	logic [DETW-1:0]  dmag_s8;
	logic [DETW-1:0]  dval_s8;
	logic             dneg_s8;
	logic [CMAGW-1:0] cmag_s8 [MATRIX_DIM][MATRIX_DIM];
	logic             cneg_s8 [MATRIX_DIM][MATRIX_DIM];
	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s8 <= dsat;
			dval_s8 <= dneg_s7 ? DETW'(-dsat) : dsat;
			dneg_s8 <= dneg_s7;
			cmag_s8 <= cmag_s7;
			cneg_s8 <= cneg_s7;
		end
	end

	// divider lanes: inverse[r][c] takes the transposed cofactor [c][r]
	logic [DW-1:0] res [MATRIX_DIM][MATRIX_DIM];
	for (genvar r = 0; r < MATRIX_DIM; r++) begin : g_row
		for (genvar c = 0; c < MATRIX_DIM; c++) begin : g_col
			minv_div u_div (
				.clk  (clk),
				.en   (en),
				.mag  (cmag_s8[c][r]),
				.neg  (cneg_s8[c][r] ^ dneg_s8),
				.dmag (dmag_s8),
				.res  (res[r][c])
			);
		end
	end

	// determinant and flag ride alongside the divider lanes
	logic [DETW-1:0] det_s [0:DIV_LAT-1];
	logic            sng_s [0:DIV_LAT-1];
	always_ff @(posedge clk) begin
		if (en) begin
			det_s[0] <= dval_s8;
			sng_s[0] <= (dmag_s8 == '0);
			for (int k = 1; k < DIV_LAT; k++) begin
				det_s[k] <= det_s[k-1];
				sng_s[k] <= sng_s[k-1];
			end
		end
	end

	always_comb begin
		inv.data.inv_r0c0  = res[0][0];
		inv.data.inv_r0c1  = res[0][1];
		inv.data.inv_r0c2  = res[0][2];
		inv.data.inv_r1c0  = res[1][0];
		inv.data.inv_r1c1  = res[1][1];
		inv.data.inv_r1c2  = res[1][2];
		inv.data.inv_r2c0  = res[2][0];
		inv.data.inv_r2c1  = res[2][1];
		inv.data.inv_r2c2  = res[2][2];
		inv.data.det_value = det_s[DIV_LAT-1];
		inv.data.singular  = sng_s[DIV_LAT-1];
	end

endmodule

// ----- rtl/core/minv_chk.sv -----
// port-level checker for the matrix inverse and its bind to the top level
module minv_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                mtx_ready,
	input logic                inv_valid,
	input logic                inv_ready,
	input minv_pkg::inv_item_t inv_data
);
	import minv_pkg::*;

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && !inv_ready |=> inv_valid)
		else $error("result valid dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && !inv_ready |=> $stable(inv_data))
		else $error("result changed while stalled");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv_data.singular |->
			inv_data.inv_r0c0 == '0 && inv_data.inv_r0c1 == '0 && inv_data.inv_r0c2 == '0 &&
			inv_data.inv_r1c0 == '0 && inv_data.inv_r1c1 == '0 && inv_data.inv_r1c2 == '0 &&
			inv_data.inv_r2c0 == '0 && inv_data.inv_r2c1 == '0 && inv_data.inv_r2c2 == '0)
		else $error("singular result carries nonzero inverse");

	a_sing_det: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid |-> inv_data.singular == (inv_data.det_value == '0))
		else $error("singular flag disagrees with determinant");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!inv_valid |-> mtx_ready)
		else $error("input blocked while output is empty");

endmodule

bind matrix_inverse_3x3 minv_chk u_minv_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.mtx_ready (mtx.ready),
	.inv_valid (inv.valid),
	.inv_ready (inv.ready),
	.inv_data  (inv.data)
);
